>>> design/lprc_pkg.sv
// Shared types and constants for the learning progress region chooser.
package lprc_pkg;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_WRITE,
    ST_READ,
    ST_SUM,
    ST_LAUNCH,
    ST_DIV,
    ST_DIFF,
    ST_SCAN,
    ST_DONE
  } lprc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic norm_start;
    logic ring_write;
    logic sum_clear;
    logic rd_step;
    logic acc_step;
    logic div_start;
    logic diff_store;
    logic scan_clear;
    logic scan_step;
    logic out_fire;
  } lprc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic norm_done;
    logic rd_last;
    logic div_done;
    logic scan_last;
    logic region_ok;
  } lprc_sts_t;

  localparam logic signed [31:0] MINUS_ONE_Q16 = -32'sd65536;

endpackage

>>> design/learning_progress_region_chooser.sv
// Top level of the learning progress region chooser.
//
// Usage: pulse start with in_region, in_raw_error and in_timestep_count while
// busy is low; the transaction is taken at that edge. The error is normalized
// by a shared bit-serial divider, written into the region's ring, the ring is
// read back one word per cycle into earlier and later sums, both sums are
// divided, and the saturated difference becomes the region's progress. Then
// all regions in use are scanned one per cycle for the best progress.
// The result appears on out_progress, out_best_region and out_none_chosen for
// exactly one cycle with out_valid high; busy drops the cycle after.
// Items are handled one at a time, so a new start is taken at the earliest
// in the cycle after the strobe. cfg_regions_in_use is written with cfg_we
// while idle; the user must keep to this, as the block does not enforce it.
// Reset clears fill, head and progress of every region and sets the scan
// count to 16; the ring memory itself is not cleared, no clearing pass runs.
// The receiver cannot stall: each result must be taken when strobed.
module learning_progress_region_chooser #(
  parameter int REGIONS    = 16,
  parameter int SMOOTH_LEN = 8,
  parameter int WINDOW_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_region,
  input  logic [31:0]        in_raw_error,
  input  logic [15:0]        in_timestep_count,
  output logic               out_valid,
  output logic signed [31:0] out_progress,
  output logic [3:0]         out_best_region,
  output logic               out_none_chosen,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_regions_in_use
);

  import lprc_pkg::*;

  lprc_cmd_t  cmd;
  lprc_sts_t  sts;
  logic [4:0] regions_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) regions_r <= 5'd16;
    else if (cfg_we) regions_r <= cfg_regions_in_use;
  end

  lprc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  lprc_datapath #(
    .REGIONS(REGIONS), .SMOOTH_LEN(SMOOTH_LEN), .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_region(in_region), .in_raw_error(in_raw_error),
    .in_timestep_count(in_timestep_count), .cfg_regions(regions_r),
    .progress(out_progress), .best_region(out_best_region),
    .none_chosen(out_none_chosen)
  );

  assign out_valid = cmd.out_fire;

endmodule

>>> design/lprc_ram.sv
// Generic single-port RAM with registered read.
module lprc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/lprc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module lprc_divider #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  assign quot = q_r;
  assign done = done_r;

  // Shift in one numerator bit and try to subtract the divisor.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

endmodule

>>> design/lprc_ctrl.sv
// Controller state machine sequencing one transaction.
module lprc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output lprc_pkg::lprc_cmd_t cmd,
  input  lprc_pkg::lprc_sts_t sts
);

  import lprc_pkg::*;

  lprc_state_t state_r, state_nxt;
  logic        div_phase_r, div_phase_nxt;

  assign busy = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    div_phase_nxt = div_phase_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_nxt  = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!sts.region_ok) begin
          cmd.scan_clear = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          cmd.norm_start = 1'b1;
          state_nxt      = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.norm_done) begin
          cmd.ring_write = 1'b1;
          cmd.sum_clear  = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        // Address is presented; data arrives next cycle.
        cmd.rd_step = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_step = 1'b1;
        cmd.rd_step  = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        // Both sums are complete here, so the first division can start.
        cmd.div_start = 1'b1;
        div_phase_nxt = 1'b0;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (!div_phase_r) begin
            cmd.div_start = 1'b1;
            div_phase_nxt = 1'b1;
          end else begin
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff_store = 1'b1;
        cmd.scan_clear = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.out_fire = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_phase_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_phase_r <= div_phase_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A result strobe always closes a busy period.
  a_fire_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fire |=> !busy) else $error("out_fire did not end transaction");
  // Loading only happens from idle.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  // The scan is always prepared before it steps.
  a_scan_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_clear |=> state_r == ST_SCAN) else $error("scan_clear misplaced");
`endif

endmodule

>>> design/lprc_datapath.sv
// Datapath: ring memory, sums, dividers, progress table and selection scan.
module lprc_datapath #(
  parameter int REGIONS    = 16,
  parameter int SMOOTH_LEN = 8,
  parameter int WINDOW_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lprc_pkg::lprc_cmd_t cmd,
  output lprc_pkg::lprc_sts_t sts,
  input  logic [3:0]          in_region,
  input  logic [31:0]         in_raw_error,
  input  logic [15:0]         in_timestep_count,
  input  logic [4:0]          cfg_regions,
  output logic signed [31:0]  progress,
  output logic [3:0]          best_region,
  output logic                none_chosen
);

  import lprc_pkg::*;

  localparam int L   = SMOOTH_LEN + WINDOW_LEN;
  localparam int LW  = $clog2(L + 1);
  localparam int SW  = (L > 1) ? $clog2(L) : 1;
  localparam int RW  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int AW  = $clog2(REGIONS * L);
  localparam int SUMW = 32 + LW;
  localparam int NW  = SUMW + LW;
  localparam int DENW = $clog2(L * SMOOTH_LEN + L + 1);
  localparam int CNTW = $clog2(REGIONS + 1);

  // Item registers.
  logic [3:0]  reg_r;
  logic [31:0] raw_r;
  logic [15:0] len_r;
  logic        ok;
  logic [RW-1:0] ridx;

  assign ok   = ({28'd0, reg_r} < 32'(REGIONS));
  assign ridx = RW'(reg_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reg_r <= in_region;
      raw_r <= in_raw_error;
      len_r <= in_timestep_count;
    end
  end

  // Per-region fill, head and latest progress.
  logic [LW-1:0]      fill_r [REGIONS];
  logic [SW-1:0]      head_r [REGIONS];
  logic signed [31:0] prog_r [REGIONS];
  logic [LW-1:0]      n_new;
  logic [SW-1:0]      head_cur, oldest;

  assign head_cur = head_r[ridx];
  assign n_new    = (fill_r[ridx] < LW'(L)) ? fill_r[ridx] + 1'b1 : fill_r[ridx];
  // Oldest slot: head after the write minus n, modulo L.
  logic [SW+1:0] old_tmp;
  always_comb begin
    old_tmp = (SW+2)'(head_cur) + (SW+2)'(1) + (SW+2)'(L) - (SW+2)'(n_new);
    if (old_tmp >= (SW+2)'(L)) old_tmp = old_tmp - (SW+2)'(L);
    if (old_tmp >= (SW+2)'(L)) old_tmp = old_tmp - (SW+2)'(L);
    oldest = SW'(old_tmp);
  end

  // Single shared divider.
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_q;
  logic [31:0]   div_den;

  lprc_divider #(.NW(NW), .DW(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(div_den), .quot(div_q), .done(div_done)
  );

  // Normalized error with saturation.
  logic [31:0] norm_err;
  always_comb begin
    if (len_r == 16'd0 || div_q[NW-1:32] != '0) norm_err = 32'hFFFF_FFFF;
    else norm_err = div_q[31:0];
  end

  // Ring memory.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_rd;
  logic [SW-1:0] rd_slot_r, rd_slot_nxt;
  logic [LW-1:0] acc_i_r;    // index of word arriving

  lprc_ram #(.WIDTH(32), .DEPTH(REGIONS * L)) u_ring (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(norm_err), .rdata(ram_rd)
  );

  assign ram_we = cmd.ring_write;
  always_comb begin
    if (cmd.ring_write) ram_addr = AW'(ridx) * AW'(L) + AW'(head_cur);
    else ram_addr = AW'(ridx) * AW'(L) + AW'(rd_slot_r);
  end
  assign rd_slot_nxt = (rd_slot_r == SW'(L - 1)) ? '0 : rd_slot_r + 1'b1;

  // Window bounds for the current fill.
  logic [LW-1:0] n_r, k_early_r, start_late_r;
  logic [SUMW-1:0] sum_e_r, sum_l_r;
  logic [DENW-1:0] den_r;

  always_ff @(posedge clk) begin
    if (cmd.ring_write) begin
      n_r          <= n_new;
      k_early_r    <= LW'((32'(n_new) * SMOOTH_LEN + L - 1) / L);
      start_late_r <= LW'((32'(n_new) * WINDOW_LEN) / L);
      den_r        <= DENW'(32'(n_new) * SMOOTH_LEN + L);
      rd_slot_r    <= oldest;
      acc_i_r      <= '0;
    end else begin
      if (cmd.rd_step) begin
        rd_slot_r <= rd_slot_nxt;
      end
      if (cmd.acc_step) acc_i_r <= acc_i_r + 1'b1;
    end
    if (cmd.sum_clear) begin
      sum_e_r <= '0;
      sum_l_r <= '0;
    end else if (cmd.acc_step) begin
      if (acc_i_r < k_early_r) sum_e_r <= sum_e_r + SUMW'(ram_rd);
      if (acc_i_r >= start_late_r) sum_l_r <= sum_l_r + SUMW'(ram_rd);
    end
  end

  // Divider operand selection: normalize, then early, then late.
  logic [NW-1:0] q_early_r;
  logic          div_sel_r;
  always_comb begin
    div_start = cmd.norm_start | cmd.div_start;
    if (cmd.norm_start) begin
      div_num = NW'({raw_r, 1'b0});
      div_den = 32'(len_r);
    end else if (!div_sel_r) begin
      div_num = NW'(sum_e_r) * NW'(L);
      div_den = 32'(den_r);
    end else begin
      div_num = NW'(sum_l_r) * NW'(L);
      div_den = 32'(den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clear) div_sel_r <= 1'b0;
    else if (cmd.div_start && !div_sel_r) div_sel_r <= 1'b1;
    if (cmd.div_start && div_sel_r) q_early_r <= div_q;
  end

  // Progress difference with saturation.
  logic signed [NW:0] diff;
  logic signed [31:0] diff_sat;
  always_comb begin
    diff = $signed({1'b0, q_early_r}) - $signed({1'b0, div_q});
    if (diff > $signed((NW+1)'(32'h7FFF_FFFF))) diff_sat = 32'sh7FFF_FFFF;
    else if (diff < -$signed((NW+1)'(33'h0_8000_0000))) diff_sat = 32'sh8000_0000;
    else diff_sat = 32'(diff);
  end

  // Scan over stored progress.
  logic [CNTW-1:0]    scan_i_r, scan_cnt;
  logic signed [31:0] best_val_r;
  logic [RW-1:0]      best_idx_r;
  logic               found_r;
  logic signed [31:0] prog_out_r;
  logic signed [31:0] cand;

  assign scan_cnt = (32'(cfg_regions) > 32'(REGIONS)) ? CNTW'(REGIONS) : CNTW'(cfg_regions);
  assign cand     = prog_r[scan_i_r[RW-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.load) prog_out_r <= '0;
    else if (cmd.diff_store) prog_out_r <= diff_sat;
    if (cmd.scan_clear) begin
      scan_i_r   <= '0;
      best_val_r <= MINUS_ONE_Q16;
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step && scan_i_r < scan_cnt) begin
      scan_i_r <= scan_i_r + 1'b1;
      if (cand > best_val_r) begin
        best_val_r <= cand;
        best_idx_r <= scan_i_r[RW-1:0];
        found_r    <= 1'b1;
      end
    end
  end

  // Per-region state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REGIONS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
        prog_r[i] <= '0;
      end
    end else begin
      if (cmd.ring_write) begin
        fill_r[ridx] <= n_new;
        head_r[ridx] <= (head_cur == SW'(L - 1)) ? '0 : head_cur + 1'b1;
      end
      if (cmd.diff_store) prog_r[ridx] <= diff_sat;
    end
  end

  assign sts.norm_done = div_done;
  assign sts.div_done  = div_done;
  assign sts.rd_last   = (acc_i_r == n_r - 1'b1);
  assign sts.scan_last = (scan_i_r >= scan_cnt);
  assign sts.region_ok = ok;

  assign progress    = prog_out_r;
  assign best_region = found_r ? 4'(best_idx_r) : 4'd0;
  assign none_chosen = !found_r;

`ifndef NO_ASSERTIONS
  // Ring read count never passes the fill.
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_step |-> acc_i_r < n_r) else $error("sum ran past fill");
  // A found best is always above minus one.
  a_best: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fire && found_r |-> best_val_r > MINUS_ONE_Q16) else $error("bad best");
  // Fill never exceeds the ring length.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ring_write |=> n_r <= LW'(L)) else $error("fill overflow");
`endif

endmodule
